### sv/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants for the CORDIC cartesian-to-polar core
// Word type carried along the cell chain, arctangent and gain tables.
// ----------------------------------------------------------------------------
package ccp_pkg;

  // field widths
  localparam int IN_W     = 30;
  localparam int RADIUS_W = 30;
  localparam int ANGLE_W  = 28;
  localparam int FRAC_W   = 24;
  // x/y datapath: input magnitude 2^29, times sqrt(2) and CORDIC growth < 2^31
  localparam int XY_W     = 33;
  localparam int GAIN_W   = 25;
  localparam int PROD_W   = XY_W + GAIN_W;
  localparam int MAX_STEPS = 24;

  localparam logic signed [ANGLE_W-1:0] PI_Q24 = 28'sd52707178;

  // atan(2^-i) in Q4.24
  localparam logic signed [ANGLE_W-1:0] ATAN_TAB [MAX_STEPS] = '{
    28'sd13176794, 28'sd7778716, 28'sd4110059, 28'sd2086330, 28'sd1047213,
    28'sd524117,   28'sd262122,  28'sd131069,  28'sd65535,   28'sd32767,
    28'sd16383,    28'sd8191,    28'sd4095,    28'sd2047,    28'sd1023,
    28'sd511,      28'sd255,     28'sd127,     28'sd64,      28'sd31,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  // gain correction for n steps, indexed by n-1, Q1.24
  localparam logic signed [GAIN_W-1:0] GAIN_TAB [MAX_STEPS] = '{
    25'sd11863283, 25'sd10610843, 25'sd10294029, 25'sd10214538,
    25'sd10194646, 25'sd10189671, 25'sd10188428, 25'sd10188117,
    25'sd10188039, 25'sd10188020, 25'sd10188015, 25'sd10188014,
    25'sd10188013, 25'sd10188013, 25'sd10188013, 25'sd10188013,
    25'sd10188013, 25'sd10188013, 25'sd10188013, 25'sd10188013,
    25'sd10188013, 25'sd10188013, 25'sd10188013, 25'sd10188013
  };

  // word handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [ANGLE_W-1:0] theta;
  } vec_t;

endpackage

### sv/ccp_cell.sv
// ----------------------------------------------------------------------------
// ccp_cell: one CORDIC vectoring micro-rotation
// Rotates by +/-atan(2^-STAGE) toward y = 0 and registers the word.
// ----------------------------------------------------------------------------
module ccp_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ccp_pkg::vec_t vec_in,
  output ccp_pkg::vec_t vec_out
);

  localparam logic signed [ccp_pkg::ANGLE_W-1:0] ATAN = ccp_pkg::ATAN_TAB[STAGE];

  ccp_pkg::vec_t vec_r;
  ccp_pkg::vec_t vec_nxt;

  logic signed [ccp_pkg::XY_W-1:0] xs;
  logic signed [ccp_pkg::XY_W-1:0] ys;
  logic                            y_neg;

  // micro-rotation; arithmetic shift floors
  always_comb begin
    xs     = $signed(vec_in.x) >>> STAGE;
    ys     = $signed(vec_in.y) >>> STAGE;
    y_neg  = vec_in.y[ccp_pkg::XY_W-1];
    vec_nxt.valid = vec_in.valid;
    if (y_neg) begin
      vec_nxt.theta = $signed(vec_in.theta) - ATAN;
      vec_nxt.x     = $signed(vec_in.x) - ys;
      vec_nxt.y     = $signed(vec_in.y) + xs;
    end else begin
      vec_nxt.theta = $signed(vec_in.theta) + ATAN;
      vec_nxt.x     = $signed(vec_in.x) + ys;
      vec_nxt.y     = $signed(vec_in.y) - xs;
    end
  end

  // valid resets, payload free-runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else begin
      vec_r.valid <= vec_nxt.valid;
    end
    vec_r.x     <= vec_nxt.x;
    vec_r.y     <= vec_nxt.y;
    vec_r.theta <= vec_nxt.theta;
  end

  assign vec_out = vec_r;

endmodule

### sv/ccp_gain.sv
// ----------------------------------------------------------------------------
// ccp_gain: CORDIC gain correction
// Multiplies the final x by the gain constant for STEPS micro-rotations.
// ----------------------------------------------------------------------------
module ccp_gain #(
  parameter int STEPS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ccp_pkg::vec_t                      vec_in,
  output logic                               valid_out,
  output logic [ccp_pkg::RADIUS_W-1:0]       radius_out,
  output logic signed [ccp_pkg::ANGLE_W-1:0] angle_out
);

  localparam logic signed [ccp_pkg::GAIN_W-1:0] GAIN = ccp_pkg::GAIN_TAB[STEPS-1];

  logic                                valid_r;
  logic signed [ccp_pkg::PROD_W-1:0]   prod_r;
  logic signed [ccp_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [ccp_pkg::ANGLE_W-1:0]  angle_r;

  // full product, x * K
  assign prod_nxt = ccp_pkg::PROD_W'($signed(vec_in.x)) * ccp_pkg::PROD_W'(GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vec_in.valid;
    end
    prod_r  <= prod_nxt;
    angle_r <= vec_in.theta;
  end

  // >> 24 then keep the radius width
  assign valid_out  = valid_r;
  assign radius_out = prod_r[ccp_pkg::FRAC_W +: ccp_pkg::RADIUS_W];
  assign angle_out  = angle_r;

endmodule

### sv/cordic_cart_to_polar_core.sv
// ----------------------------------------------------------------------------
// cordic_cart_to_polar_core: CORDIC vectoring-mode cartesian-to-polar converter
// Folds the point into the right half plane, runs a chain of rotation cells,
// then applies the gain correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_x_in / in_y_in (signed Q6.24) with start high; a word is
//   taken at every rising edge where start is high and busy is low. busy is
//   always low, so a new point can enter every cycle.
//   Output: out_valid pulses for one cycle with out_radius (Q6.24, unsigned)
//   and out_angle (radians, signed Q4.24). The receiver cannot hold results
//   off; each result must be captured in its strobe cycle.
//   Pipeline: from start to out_valid a point passes one fold stage, one
//   register per rotation cell and one multiply stage.
//   Throughput: one point per cycle; every cell and the 33x25 gain multiplier
//   are fully pipelined.
//   Reset: synchronous, active low; clears the valid bits along the chain so
//   no stale result is strobed. Data registers are not reset.
// ----------------------------------------------------------------------------
module cordic_cart_to_polar_core #(
  parameter int ITERATIONS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ccp_pkg::IN_W-1:0]    in_x_in,
  input  logic signed [ccp_pkg::IN_W-1:0]    in_y_in,
  output logic                               out_valid,
  output logic [ccp_pkg::RADIUS_W-1:0]       out_radius,
  output logic signed [ccp_pkg::ANGLE_W-1:0] out_angle
);

  localparam int EXT_W = ccp_pkg::XY_W - ccp_pkg::IN_W;

  ccp_pkg::vec_t fold_r;
  ccp_pkg::vec_t fold_nxt;
  ccp_pkg::vec_t chain [ITERATIONS+1];

  logic signed [ccp_pkg::XY_W-1:0] x_ext;
  logic signed [ccp_pkg::XY_W-1:0] y_ext;

  assign busy = 1'b0;

  // fold into right half plane, seed angle with +/-pi
  always_comb begin
    x_ext = {{EXT_W{in_x_in[ccp_pkg::IN_W-1]}}, in_x_in};
    y_ext = {{EXT_W{in_y_in[ccp_pkg::IN_W-1]}}, in_y_in};
    fold_nxt.valid = start && !busy;
    if (in_x_in[ccp_pkg::IN_W-1]) begin
      fold_nxt.x     = -x_ext;
      fold_nxt.y     = -y_ext;
      fold_nxt.theta = in_y_in[ccp_pkg::IN_W-1] ? -ccp_pkg::PI_Q24 : ccp_pkg::PI_Q24;
    end else begin
      fold_nxt.x     = x_ext;
      fold_nxt.y     = y_ext;
      fold_nxt.theta = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.valid <= 1'b0;
    end else begin
      fold_r.valid <= fold_nxt.valid;
    end
    fold_r.x     <= fold_nxt.x;
    fold_r.y     <= fold_nxt.y;
    fold_r.theta <= fold_nxt.theta;
  end

  assign chain[0] = fold_r;

  // rotation cells
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    ccp_cell #(
      .STAGE(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vec_in  (chain[i]),
      .vec_out (chain[i+1])
    );
  end

  // gain correction and output
  ccp_gain #(
    .STEPS(ITERATIONS)
  ) u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .vec_in     (chain[ITERATIONS]),
    .valid_out  (out_valid),
    .radius_out (out_radius),
    .angle_out  (out_angle)
  );

endmodule
